@@ rtl/rscc_pkg.sv @@
// Shared constants, types and calendar tables for the seconds/calendar converter.
// No dependencies; imported by every module in rtl/.
package rscc_pkg;

    // Pipeline depth: registered stages from input to output
    localparam int NST = 6;

    localparam logic [31:0] SEC_PER_DAY    = 32'd86400;
    localparam logic [16:0] SEC_PER_HOUR   = 17'd3600;
    localparam logic [16:0] SEC_PER_MIN    = 17'd60;
    localparam logic [16:0] DAYS_PER_CYCLE = 17'd1461;  // four-year cycle
    localparam logic [16:0] EPOCH_WDAY     = 17'd6;     // 2000-01-01 was a Saturday
    localparam logic [3:0]  LAST_MONTH_IDX = 4'd11;
    localparam logic [3:0]  MONTHS         = 4'd12;

    // Exact reciprocals: q = (x * RECIP) >> SHIFT for the full input range
    localparam logic [25:0] RECIP_DAY  = 26'd50903317; // (cnt >> 7) / 675
    localparam logic [16:0] RECIP_CYC  = 17'd91868;    // days / 1461
    localparam logic [17:0] RECIP_WK   = 18'd149797;   // days / 7
    localparam logic [13:0] RECIP_HR   = 14'd9321;     // (tod >> 4) / 225
    localparam logic [10:0] RECIP_MIN  = 11'd1093;     // (rem >> 2) / 15

    typedef struct packed {
        logic [NST-1:0] load;       // per-stage register enable
        logic           out_valid;  // last stage holds an item
        logic           out_mode;   // direction of that item
    } pipe_ctrl_t;

    // Day offset of a year within the four-year cycle (first year is leap)
    function automatic logic [10:0] year_start(input logic [1:0] phase);
        logic [10:0] d;
        case (phase)
            2'd0:    d = 11'd0;
            2'd1:    d = 11'd366;
            2'd2:    d = 11'd731;
            2'd3:    d = 11'd1096;
            default: d = 11'd0;
        endcase
        return d;
    endfunction

    // Day offset of month index 0..11 within its year
    function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
        logic [8:0] d;
        case (idx)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        if (leap && (idx >= 4'd2)) begin
            d = d + 9'd1;
        end
        return d;
    endfunction

endpackage

@@ rtl/rscc_ctrl.sv @@
// Valid/ready bookkeeping for the converter pipeline: per-stage valid and mode bits.
// Depends on rscc_pkg (NST, pipe_ctrl_t).
module rscc_ctrl import rscc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  logic       in_mode,
    output logic       in_ready,
    input  logic       out_ready,
    output pipe_ctrl_t ctrl
);

    logic [NST-1:0] valid_reg, valid_next;
    logic [NST-1:0] mode_reg,  mode_next;
    logic [NST-1:0] rdy;

    // A stage takes new contents when it is empty or its contents move on
    always_comb begin
        rdy[NST-1] = !valid_reg[NST-1] || out_ready;
        for (int i = NST-2; i >= 0; i--) begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        mode_next  = mode_reg;
        if (rdy[0]) begin
            valid_next[0] = in_valid;
            mode_next[0]  = in_mode;
        end
        for (int i = 1; i < NST; i++) begin
            if (rdy[i]) begin
                valid_next[i] = valid_reg[i-1];
                mode_next[i]  = mode_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
        mode_reg <= mode_next;
    end

    assign in_ready       = rdy[0];
    assign ctrl.load      = rdy;
    assign ctrl.out_valid = valid_reg[NST-1];
    assign ctrl.out_mode  = mode_reg[NST-1];

endmodule

@@ rtl/rscc_cal2cnt.sv @@
// Calendar-to-seconds datapath: day count and time of day, then one scaled add,
// then a delay line to match the pipeline depth. Depends on rscc_pkg.
module rscc_cal2cnt import rscc_pkg::*; (
    input  logic           aclk,
    input  logic [NST-1:0] load,
    input  logic [7:0]     year_in,
    input  logic [3:0]     month_in,
    input  logic [4:0]     day_in,
    input  logic [4:0]     hour_in,
    input  logic [5:0]     minute_in,
    input  logic [5:0]     second_in,
    output logic [31:0]    count_out
);

    logic [17:0] days0_reg, days0_next;   // two's complement, -1 when day 0 at epoch
    logic [16:0] tod0_reg,  tod0_next;
    logic [3:0]  lim;
    logic [1:0]  phase;
    logic [31:0] days_sx;
    logic [31:0] cnt_line_reg [1:NST-1];
    logic [31:0] count1_next;

    // Stage 0: days since epoch and seconds into the day
    always_comb begin
        phase = year_in[1:0];
        if (month_in == 4'd0) begin
            lim = 4'd0;
        end else if (month_in > MONTHS) begin
            lim = LAST_MONTH_IDX;
        end else begin
            lim = month_in - 4'd1;
        end
        days0_next = 18'(17'(year_in[7:2]) * DAYS_PER_CYCLE)
                   + 18'(year_start(phase))
                   + 18'(month_start(phase == 2'd0, lim))
                   + 18'(day_in) - 18'd1;
        tod0_next  = 17'(hour_in) * SEC_PER_HOUR
                   + 17'(minute_in) * SEC_PER_MIN
                   + 17'(second_in);
    end

    // Stage 1: scale days to seconds, wrap to 32 bits
    always_comb begin
        days_sx     = {{14{days0_reg[17]}}, days0_reg};
        count1_next = days_sx * SEC_PER_DAY + 32'(tod0_reg);
    end

    always_ff @(posedge aclk) begin
        if (load[0]) begin
            days0_reg <= days0_next;
            tod0_reg  <= tod0_next;
        end
        if (load[1]) begin
            cnt_line_reg[1] <= count1_next;
        end
        for (int i = 2; i < NST; i++) begin
            if (load[i]) begin
                cnt_line_reg[i] <= cnt_line_reg[i-1];
            end
        end
    end

    assign count_out = cnt_line_reg[NST-1];

endmodule

@@ rtl/rscc_cnt2cal.sv @@
// Seconds-to-calendar datapath: six stages of reciprocal divides, remainders,
// year and month searches. Depends on rscc_pkg.
module rscc_cnt2cal import rscc_pkg::*; (
    input  logic           aclk,
    input  logic [NST-1:0] load,
    input  logic [31:0]    count_in,
    output logic [7:0]     year_out,
    output logic [3:0]     month_out,
    output logic [4:0]     day_out,
    output logic [4:0]     hour_out,
    output logic [5:0]     minute_out,
    output logic [5:0]     second_out,
    output logic [2:0]     weekday_out
);

    // stage 0
    logic [31:0] cnt0_reg, cnt0_next;
    logic [15:0] day0_reg, day0_next;
    logic [50:0] prod0;
    // stage 1
    logic [15:0] day1_reg;
    logic [16:0] tod1_reg, tod1_next;
    logic [31:0] tod1_full;
    // stage 2
    logic [15:0] day2_reg;
    logic [5:0]  q4_2_reg, q4_2_next;
    logic [16:0] wdarg2_reg, wdarg2_next;
    logic [12:0] qw2_reg, qw2_next;
    logic [4:0]  hour2_reg, hour2_next;
    logic [16:0] tod2_reg;
    logic [32:0] pc2;
    logic [34:0] pw2;
    logic [26:0] ph2;
    // stage 3
    logic [5:0]  q4_3_reg;
    logic [10:0] rem3_reg, rem3_next;
    logic [2:0]  wd3_reg, wd3_next;
    logic [4:0]  hour3_reg;
    logic [11:0] remh3_reg, remh3_next;
    logic [15:0] rem3_full;
    logic [16:0] wd3_full, remh3_full;
    // stage 4
    logic [7:0]  year4_reg, year4_next;
    logic [8:0]  remy4_reg, remy4_next;
    logic        leap4_reg, leap4_next;
    logic [2:0]  wd4_reg;
    logic [4:0]  hour4_reg;
    logic [5:0]  min4_reg, min4_next;
    logic [11:0] remh4_reg;
    logic [1:0]  y4;
    logic [10:0] remy4_full;
    logic [20:0] pm4;
    // stage 5
    logic [3:0]  month5_next;
    logic [4:0]  day5_next;
    logic [5:0]  sec5_next;
    logic [3:0]  midx;
    logic [8:0]  day5_full;
    logic [11:0] sec5_full;
    logic [7:0]  year5_reg;
    logic [3:0]  month5_reg;
    logic [4:0]  day5_reg, hour5_reg;
    logic [5:0]  min5_reg, sec5_reg;
    logic [2:0]  wd5_reg;

    // Stage 0: whole days = (cnt >> 7) / 675
    always_comb begin
        cnt0_next = count_in;
        prod0     = 51'(count_in[31:7]) * 51'(RECIP_DAY);
        day0_next = prod0[50:35];
    end

    // Stage 1: seconds into the day
    always_comb begin
        tod1_full = cnt0_reg - 32'(day0_reg) * SEC_PER_DAY;
        tod1_next = tod1_full[16:0];
    end

    // Stage 2: quotients by 1461, 7 and 3600
    always_comb begin
        pc2         = 33'(day1_reg) * 33'(RECIP_CYC);
        q4_2_next   = pc2[32:27];
        wdarg2_next = 17'(day1_reg) + EPOCH_WDAY;
        pw2         = 35'(wdarg2_next) * 35'(RECIP_WK);
        qw2_next    = pw2[32:20];
        ph2         = 27'(tod1_reg[16:4]) * 27'(RECIP_HR);
        hour2_next  = ph2[25:21];
    end

    // Stage 3: remainders
    always_comb begin
        rem3_full  = day2_reg - 16'(q4_2_reg) * 16'(DAYS_PER_CYCLE);
        rem3_next  = rem3_full[10:0];
        wd3_full   = wdarg2_reg - 17'(qw2_reg) * 17'd7;
        wd3_next   = wd3_full[2:0];
        remh3_full = tod2_reg - 17'(hour2_reg) * SEC_PER_HOUR;
        remh3_next = remh3_full[11:0];
    end

    // Stage 4: year within the cycle, minutes
    always_comb begin
        if (rem3_reg >= 11'd1096) begin
            y4 = 2'd3;
        end else if (rem3_reg >= 11'd731) begin
            y4 = 2'd2;
        end else if (rem3_reg >= 11'd366) begin
            y4 = 2'd1;
        end else begin
            y4 = 2'd0;
        end
        remy4_full = rem3_reg - year_start(y4);
        remy4_next = remy4_full[8:0];
        leap4_next = (y4 == 2'd0);
        year4_next = {q4_3_reg, y4};
        pm4        = 21'(remh3_reg[11:2]) * 21'(RECIP_MIN);
        min4_next  = pm4[19:14];
    end

    // Stage 5: month search over the month starts, day and second
    always_comb begin
        midx = 4'd0;
        for (int k = 1; k <= 11; k++) begin
            midx = midx + 4'(month_start(leap4_reg, 4'(k)) <= remy4_reg);
        end
        month5_next = midx + 4'd1;
        day5_full   = remy4_reg - month_start(leap4_reg, midx) + 9'd1;
        day5_next   = day5_full[4:0];
        sec5_full   = remh4_reg - 12'(min4_reg) * 12'(SEC_PER_MIN);
        sec5_next   = sec5_full[5:0];
    end

    always_ff @(posedge aclk) begin
        if (load[0]) begin
            cnt0_reg <= cnt0_next;
            day0_reg <= day0_next;
        end
        if (load[1]) begin
            day1_reg <= day0_reg;
            tod1_reg <= tod1_next;
        end
        if (load[2]) begin
            day2_reg   <= day1_reg;
            q4_2_reg   <= q4_2_next;
            wdarg2_reg <= wdarg2_next;
            qw2_reg    <= qw2_next;
            hour2_reg  <= hour2_next;
            tod2_reg   <= tod1_reg;
        end
        if (load[3]) begin
            q4_3_reg  <= q4_2_reg;
            rem3_reg  <= rem3_next;
            wd3_reg   <= wd3_next;
            hour3_reg <= hour2_reg;
            remh3_reg <= remh3_next;
        end
        if (load[4]) begin
            year4_reg <= year4_next;
            remy4_reg <= remy4_next;
            leap4_reg <= leap4_next;
            wd4_reg   <= wd3_reg;
            hour4_reg <= hour3_reg;
            min4_reg  <= min4_next;
            remh4_reg <= remh3_reg;
        end
        if (load[5]) begin
            year5_reg  <= year4_reg;
            month5_reg <= month5_next;
            day5_reg   <= day5_next;
            hour5_reg  <= hour4_reg;
            min5_reg   <= min4_reg;
            sec5_reg   <= sec5_next;
            wd5_reg    <= wd4_reg;
        end
    end

    assign year_out    = year5_reg;
    assign month_out   = month5_reg;
    assign day_out     = day5_reg;
    assign hour_out    = hour5_reg;
    assign minute_out  = min5_reg;
    assign second_out  = sec5_reg;
    assign weekday_out = wd5_reg;

endmodule

@@ rtl/rtc_seconds_calendar_convert.sv @@
// Seconds count <-> calendar converter, epoch 2000-01-01 00:00:00, 1461-day cycles.
// Each item passes through six registered stages before its result is offered.
// Throughput: one item per cycle unless stalled; the per-stage multiply sets stage depth.
// Stalls collapse bubbles: a stage loads whenever it is empty or draining.
// Reset (aresetn low, synchronous) empties the pipeline; datapath registers keep contents.
// Depends on rscc_pkg, rscc_ctrl, rscc_cal2cnt, rscc_cnt2cal.
module rtc_seconds_calendar_convert import rscc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] count_in, [39:32] year_in, [43:40] month_in, [48:44] day_in,
    // [53:49] hour_in, [59:54] minute_in, [65:60] second_in, [71:66] zero
    input  logic [71:0] s_axis_tdata,
    input  logic        s_axis_tuser,   // [0] mode: 0 calendar->seconds, 1 seconds->calendar
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] count_out, [39:32] year_out, [43:40] month_out, [48:44] day_out,
    // [53:49] hour_out, [59:54] minute_out, [65:60] second_out,
    // [68:66] weekday_out, [71:69] zero
    output logic [71:0] m_axis_tdata
);

    pipe_ctrl_t  ctrl;

    logic [31:0] c2s_count;
    logic [7:0]  s2c_year;
    logic [3:0]  s2c_month;
    logic [4:0]  s2c_day, s2c_hour;
    logic [5:0]  s2c_minute, s2c_second;
    logic [2:0]  s2c_wday;

    // Handshake and stage enables; mode travels with each item's valid bit
    rscc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_mode   (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .out_ready (m_axis_tready),
        .ctrl      (ctrl)
    );

    // Both directions are computed for every item; the output picks one
    rscc_cal2cnt u_cal2cnt (
        .aclk      (aclk),
        .load      (ctrl.load),
        .year_in   (s_axis_tdata[39:32]),
        .month_in  (s_axis_tdata[43:40]),
        .day_in    (s_axis_tdata[48:44]),
        .hour_in   (s_axis_tdata[53:49]),
        .minute_in (s_axis_tdata[59:54]),
        .second_in (s_axis_tdata[65:60]),
        .count_out (c2s_count)
    );

    rscc_cnt2cal u_cnt2cal (
        .aclk        (aclk),
        .load        (ctrl.load),
        .count_in    (s_axis_tdata[31:0]),
        .year_out    (s2c_year),
        .month_out   (s2c_month),
        .day_out     (s2c_day),
        .hour_out    (s2c_hour),
        .minute_out  (s2c_minute),
        .second_out  (s2c_second),
        .weekday_out (s2c_wday)
    );

    assign m_axis_tvalid = ctrl.out_valid;

    // Fields of the unused direction read as zero
    always_comb begin
        if (ctrl.out_mode) begin
            m_axis_tdata = {3'b000, s2c_wday, s2c_second, s2c_minute, s2c_hour,
                            s2c_day, s2c_month, s2c_year, 32'd0};
        end else begin
            m_axis_tdata = {40'd0, c2s_count};
        end
    end

`ifndef NO_ASSERTIONS
    // Pipeline is empty the cycle after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // Decoded calendar fields stay within their ranges
    a_date_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && ctrl.out_mode) |->
            (s2c_month >= 4'd1 && s2c_month <= 4'd12 &&
             s2c_day >= 5'd1 && s2c_day <= 5'd31 && s2c_wday <= 3'd6))
        else $error("date field out of range");

    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && ctrl.out_mode) |->
            (s2c_hour <= 5'd23 && s2c_minute <= 6'd59 && s2c_second <= 6'd59))
        else $error("time of day field out of range");
`endif

endmodule
